/* sv/first_fit_heap_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Clocked property helpers shared by the allocator's assertion checks.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define FFHA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FFHA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants and payload types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

   localparam int HEADER_BYTES    = 6;
   localparam int MIN_CHUNK_BYTES = 4;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_BASE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_SIZE = 8'd1;

   localparam logic [15:0] HEAP_BASE_RESET = 16'd32768;
   localparam logic [12:0] HEAP_SIZE_RESET = 13'd4096;

   typedef struct packed {
      logic        mode;
      logic [12:0] request_size;
      logic [7:0]  owner;
      logic [15:0] block_address;
   } cmd_type;

   typedef struct packed {
      logic [15:0] data_address;
      logic        success;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/ffha_if.sv */
// ----------------------------------------------------------------------------
// ffha_if
// Valid/ready channels of the allocator: request, response and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [12:0] request_size;
   logic [7:0]  owner;
   logic [15:0] block_address;
   modport source (output valid, mode, request_size, owner, block_address, input ready);
   modport sink (input valid, mode, request_size, owner, block_address, output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] data_address;
   logic        success;
   modport source (output valid, data_address, success, input ready);
   modport sink (input valid, data_address, success, output ready);
endinterface

interface ffha_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/ffha_hdr_mem.sv */
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Block header store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_hdr_mem #(
   parameter int DEPTH = 4096,
   parameter int DW    = 22,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/ffha_engine.sv */
// ----------------------------------------------------------------------------
// ffha_engine
// Walk sequencer: visits one header at a time in S_CHECK and S_EVAL, splits and merges blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_engine import ffha_pkg::*; #(
   parameter int HEAP_BYTES = 4096,
   parameter int OWNER_BITS = 8,
   localparam int SIZE_W = $clog2(HEAP_BYTES + 1),
   localparam int IDX_W  = $clog2(HEAP_BYTES),
   localparam int CW     = ((SIZE_W > 16) ? SIZE_W : 16) + 2,
   localparam int HW     = 1 + OWNER_BITS + SIZE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  cmd_type          cmd,
   input  logic             init_start,
   input  logic [15:0]      heap_base,
   input  logic [12:0]      heap_size,
   output logic             idle,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output rsp_type          rsp,
   output logic             mem_we,
   output logic [IDX_W-1:0] mem_wa,
   output logic [HW-1:0]    mem_wd,
   output logic [IDX_W-1:0] mem_ra,
   input  logic [HW-1:0]    mem_rd
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_INIT      = 9'b000000010,
      S_CHECK     = 9'b000000100,
      S_EVAL      = 9'b000001000,
      S_NEXT_RD   = 9'b000010000,
      S_NEXT_EVAL = 9'b000100000,
      S_WR_SPLIT  = 9'b001000000,
      S_WR_HDR    = 9'b010000000,
      S_RESP      = 9'b100000000
   } state_type;

   localparam logic [CW-1:0] HDR_W   = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] SPLIT_W = CW'(HEADER_BYTES + MIN_CHUNK_BYTES);
   localparam logic [CW-1:0] HEAP_W  = CW'(HEAP_BYTES);

   state_type state_ff, state_in;

   logic                  mode_ff;
   logic [CW-1:0]         req_ff;
   logic [OWNER_BITS-1:0] own_ff;
   logic [15:0]           target_ff;
   logic [CW-1:0]         span_ff, span_in;
   logic [CW-1:0]         off_ff, off_in;
   logic [CW-1:0]         prev_ff, prev_in;
   logic [SIZE_W-1:0]     prev_size_ff, prev_size_in;
   logic [OWNER_BITS-1:0] prev_own_ff, prev_own_in;
   logic                  prev_used_ff, prev_used_in;
   logic                  has_prev_ff, has_prev_in;
   logic [CW-1:0]         nx_ff, nx_in;
   logic [SIZE_W-1:0]     split_size_ff, split_size_in;
   logic [OWNER_BITS-1:0] split_own_ff, split_own_in;
   logic [SIZE_W-1:0]     hdr_size_ff, hdr_size_in;
   logic [OWNER_BITS-1:0] hdr_own_ff, hdr_own_in;
   logic                  hdr_used_ff, hdr_used_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  rd_used;
   logic [OWNER_BITS-1:0] rd_own;
   logic [CW-1:0]         rd_size;
   logic [CW-1:0]         heap_size_w;
   logic [CW-1:0]         span_calc;
   logic [CW-1:0]         next_off;
   logic [CW-1:0]         split_addr;
   logic [CW-1:0]         left;
   logic                  fits;
   logic                  do_split;
   logic                  at_target;

   assign rd_used = mem_rd[HW-1];
   assign rd_own  = mem_rd[SIZE_W +: OWNER_BITS];
   assign rd_size = CW'(mem_rd[SIZE_W-1:0]);

   assign heap_size_w = CW'(heap_size);
   assign span_calc   = (heap_size_w > HEAP_W) ? HEAP_W : heap_size_w;

   // Shared walk arithmetic: the next header follows this header and its data.
   assign next_off   = off_ff + HDR_W + rd_size;
   assign split_addr = off_ff + HDR_W + req_ff;
   assign left       = rd_size - req_ff;
   assign fits       = !rd_used && (rd_size >= req_ff);
   assign do_split   = (left > SPLIT_W) && (split_addr < span_ff);
   assign at_target  = (off_ff == CW'(target_ff));

   always_comb begin
      state_in      = state_ff;
      span_in       = span_ff;
      off_in        = off_ff;
      prev_in       = prev_ff;
      prev_size_in  = prev_size_ff;
      prev_own_in   = prev_own_ff;
      prev_used_in  = prev_used_ff;
      has_prev_in   = has_prev_ff;
      nx_in         = nx_ff;
      split_size_in = split_size_ff;
      split_own_in  = split_own_ff;
      hdr_size_in   = hdr_size_ff;
      hdr_own_in    = hdr_own_ff;
      hdr_used_in   = hdr_used_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_we        = 1'b0;
      mem_wa        = off_ff[IDX_W-1:0];
      mem_wd        = {hdr_used_ff, hdr_own_ff, hdr_size_ff};
      mem_ra        = off_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               off_in      = '0;
               has_prev_in = 1'b0;
               res_in      = '0;
               state_in    = (span_ff < HDR_W) ? S_RESP : S_CHECK;
            end
         end
         S_INIT: begin
            span_in = span_calc;
            mem_wa  = '0;
            mem_wd  = {1'b0, OWNER_BITS'(0), SIZE_W'(span_calc - HDR_W)};
            mem_we  = (span_calc >= HDR_W);
            state_in = S_IDLE;
         end
         S_CHECK: begin
            if (off_ff >= span_ff) begin
               res_in   = '0;
               state_in = S_RESP;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (mode_ff == MODE_ALLOC) begin
               if (fits) begin
                  hdr_own_in  = own_ff;
                  hdr_used_in = 1'b1;
                  if (do_split) begin
                     nx_in         = split_addr;
                     split_size_in = SIZE_W'(left - HDR_W);
                     split_own_in  = rd_own;
                     hdr_size_in   = SIZE_W'(req_ff);
                     state_in      = S_WR_SPLIT;
                  end else begin
                     hdr_size_in = SIZE_W'(rd_size);
                     state_in    = S_WR_HDR;
                  end
               end else begin
                  off_in   = next_off;
                  state_in = S_CHECK;
               end
            end else if (at_target) begin
               nx_in       = next_off;
               hdr_used_in = 1'b0;
               if (has_prev_ff && !prev_used_ff) begin
                  // The freed block folds into the free block before it.
                  off_in      = prev_ff;
                  hdr_size_in = SIZE_W'(CW'(prev_size_ff) + HDR_W + rd_size);
                  hdr_own_in  = prev_own_ff;
               end else begin
                  hdr_size_in = SIZE_W'(rd_size);
                  hdr_own_in  = '0;
               end
               state_in = (next_off < span_ff) ? S_NEXT_RD : S_WR_HDR;
            end else begin
               prev_in      = off_ff;
               prev_size_in = SIZE_W'(rd_size);
               prev_own_in  = rd_own;
               prev_used_in = rd_used;
               has_prev_in  = 1'b1;
               off_in       = next_off;
               state_in     = S_CHECK;
            end
         end
         S_NEXT_RD: begin
            mem_ra   = nx_ff[IDX_W-1:0];
            state_in = S_NEXT_EVAL;
         end
         S_NEXT_EVAL: begin
            if (!rd_used) begin
               hdr_size_in = SIZE_W'(CW'(hdr_size_ff) + HDR_W + rd_size);
            end
            state_in = S_WR_HDR;
         end
         S_WR_SPLIT: begin
            mem_we   = 1'b1;
            mem_wa   = nx_ff[IDX_W-1:0];
            mem_wd   = {1'b0, split_own_ff, split_size_ff};
            state_in = S_WR_HDR;
         end
         S_WR_HDR: begin
            mem_we              = 1'b1;
            res_in.data_address = heap_base + 16'(off_ff) + 16'(HEADER_BYTES);
            res_in.success      = 1'b1;
            state_in            = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (init_start) begin
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         has_prev_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         has_prev_ff  <= has_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == S_IDLE) begin
         mode_ff   <= cmd.mode;
         req_ff    <= CW'(cmd.request_size);
         own_ff    <= OWNER_BITS'(cmd.owner);
         target_ff <= cmd.block_address - 16'(HEADER_BYTES) - heap_base;
      end
      span_ff       <= span_in;
      off_ff        <= off_in;
      prev_ff       <= prev_in;
      prev_size_ff  <= prev_size_in;
      prev_own_ff   <= prev_own_in;
      prev_used_ff  <= prev_used_in;
      nx_ff         <= nx_in;
      split_size_ff <= split_size_in;
      split_own_ff  <= split_own_in;
      hdr_size_ff   <= hdr_size_in;
      hdr_own_ff    <= hdr_own_in;
      hdr_used_ff   <= hdr_used_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

/* sv/first_fit_heap_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with block splitting and free-block coalescing.
// ----------------------------------------------------------------------------
// Usage:
// A request on req_bus either allocates request_size bytes for owner (mode 0)
// or frees the block whose data address is block_address (mode 1). Each
// request gives exactly one response on rsp_bus: the data address and a
// success flag; a failed request returns address 0 with success low.
// Requests are taken one at a time. The walk visits one block header at a
// time through the single read port of the header memory, and the engine is
// ready for the next request in the same cycle that the response becomes
// valid. A free whose next block lies inside the heap also reads that block
// to merge it, and an allocate that splits writes a header for the remainder.
// A heap smaller than a header answers failure without walking any headers.
// csr_bus writes heap_base (index 0) or heap_size (index 1) and rebuilds the
// heap as one free block if a header fits; other indexes are ignored. Writes are
// taken at any time but belong in idle periods.
// After reset the heap is rebuilt the same way before the first request.
// The response sits in an output register; when rsp_bus is stalled the
// finished request waits there and the next request may be accepted.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_heap_allocator_top_assert.svh"

module first_fit_heap_allocator_top import ffha_pkg::*; #(
   parameter int HEAP_BYTES = 4096,
   parameter int OWNER_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   ffha_req_if.sink   req_bus,
   ffha_rsp_if.source rsp_bus,
   ffha_csr_if.sink   csr_bus
);

   localparam int SIZE_W = $clog2(HEAP_BYTES + 1);
   localparam int IDX_W  = $clog2(HEAP_BYTES);
   localparam int HW     = 1 + OWNER_BITS + SIZE_W;

   logic [15:0] heap_base_ff, heap_base_in;
   logic [12:0] heap_size_ff, heap_size_in;
   logic        csr_write;
   logic        init_start;
   logic        engine_idle;
   logic        accept;
   cmd_type     cmd;
   rsp_type     rsp;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [HW-1:0]    mem_wd;
   logic [IDX_W-1:0] mem_ra;
   logic [HW-1:0]    mem_rd;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid;

   always_comb begin
      heap_base_in = heap_base_ff;
      heap_size_in = heap_size_ff;
      init_start   = 1'b0;
      if (csr_write) begin
         case (csr_bus.index)
            REG_HEAP_BASE: begin
               heap_base_in = csr_bus.data;
               init_start   = 1'b1;
            end
            REG_HEAP_SIZE: begin
               heap_size_in = csr_bus.data[12:0];
               init_start   = 1'b1;
            end
            default: begin
               init_start = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= HEAP_BASE_RESET;
         heap_size_ff <= HEAP_SIZE_RESET;
      end else begin
         heap_base_ff <= heap_base_in;
         heap_size_ff <= heap_size_in;
      end
   end

   assign req_bus.ready = engine_idle;
   assign accept        = req_bus.valid && engine_idle;

   assign cmd.mode          = req_bus.mode;
   assign cmd.request_size  = req_bus.request_size;
   assign cmd.owner         = req_bus.owner;
   assign cmd.block_address = req_bus.block_address;

   ffha_hdr_mem #(
      .DEPTH (HEAP_BYTES),
      .DW    (HW)
   ) u_hdr_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   ffha_engine #(
      .HEAP_BYTES (HEAP_BYTES),
      .OWNER_BITS (OWNER_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .cmd        (cmd),
      .init_start (init_start),
      .heap_base  (heap_base_ff),
      .heap_size  (heap_size_ff),
      .idle       (engine_idle),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp        (rsp),
      .mem_we     (mem_we),
      .mem_wa     (mem_wa),
      .mem_wd     (mem_wd),
      .mem_ra     (mem_ra),
      .mem_rd     (mem_rd)
   );

   assign rsp_bus.data_address = rsp.data_address;
   assign rsp_bus.success      = rsp.success;

   // A request occupies the engine, a register write rebuilds the heap, and a failed response has address 0.
   `FFHA_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_bus.ready, "ready after accept")
   `FFHA_ASSERT_NXT(a_busy_after_init, clock, reset, init_start, !req_bus.ready, "ready during init")
   `FFHA_ASSERT_IMP(a_fail_zero_addr, clock, reset, rsp_bus.valid && !rsp_bus.success, rsp_bus.data_address == 16'd0, "failed request with address")

endmodule

`default_nettype wire

/* test/first_fit_heap_allocator_top_tb.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top_tb
// Self-checking bench for the first-fit heap allocator. A table of directed
// requests runs first. Random allocate and free traffic follows under several
// heap settings. Every response is checked against its fixed table entry or an
// in-bench model of the block chain. Requests idle and responses stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator_top_tb;
   import ffha_pkg::*;

   localparam int HEAP_LIMIT   = 4096;
   localparam int CYCLE_LIMIT  = 20000000;
   localparam int ITEMS_PHASE  = 250;
   localparam int HOLD_CYCLES  = 3000;

   logic clock;
   logic reset;

   ffha_req_if req_bus();
   ffha_rsp_if rsp_bus();
   ffha_csr_if csr_bus();

   first_fit_heap_allocator_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Model of the heap chain: data size and allocated mark at each block start.
   int          chain_size [HEAP_LIMIT];
   bit          blk_used [HEAP_LIMIT];
   logic [15:0] heap_base;
   logic [12:0] heap_size;
   int          heap_span;

   rsp_type     expected_rsp[$];
   logic [15:0] live_blocks[$];
   int          errors = 0;
   int          accepted = 0;
   bit          hold_done = 0;

   function automatic void heap_rebuild();
      heap_span = (heap_size > HEAP_LIMIT) ? HEAP_LIMIT : int'(heap_size);
      foreach (chain_size[i]) begin
         chain_size[i] = 0;
         blk_used[i] = 1'b0;
      end
      if (heap_span >= HEADER_BYTES) chain_size[0] = heap_span - HEADER_BYTES;
   endfunction

   function automatic rsp_type heap_predict(cmd_type c);
      int off, prev, nx, target, need;
      bit has_prev;
      rsp_type r;
      r = '0;
      off = 0;
      prev = 0;
      has_prev = 1'b0;
      need = int'(c.request_size);
      if (heap_span < HEADER_BYTES) return r;
      if (c.mode == MODE_ALLOC) begin
         while (off < heap_span) begin
            if (!blk_used[off] && chain_size[off] >= need) begin
               if (chain_size[off] - need > HEADER_BYTES + MIN_CHUNK_BYTES) begin
                  nx = off + HEADER_BYTES + need;
                  if (nx < heap_span) begin
                     chain_size[nx] = chain_size[off] - need - HEADER_BYTES;
                     blk_used[nx] = 1'b0;
                     chain_size[off] = need;
                  end
               end
               blk_used[off] = 1'b1;
               r.data_address = 16'(heap_base + off + HEADER_BYTES);
               r.success = 1'b1;
               return r;
            end
            off = off + HEADER_BYTES + chain_size[off];
         end
         return r;
      end
      target = int'(16'(c.block_address - HEADER_BYTES - heap_base));
      while (off < heap_span && off != target) begin
         prev = off;
         has_prev = 1'b1;
         off = off + HEADER_BYTES + chain_size[off];
      end
      if (off >= heap_span) return r;
      blk_used[off] = 1'b0;
      if (has_prev && !blk_used[prev]) begin
         chain_size[prev] += HEADER_BYTES + chain_size[off];
         off = prev;
      end
      nx = off + HEADER_BYTES + chain_size[off];
      if (nx < heap_span && !blk_used[nx]) chain_size[off] += HEADER_BYTES + chain_size[nx];
      r.data_address = 16'(heap_base + off + HEADER_BYTES);
      r.success = 1'b1;
      return r;
   endfunction

   // Sender burst state.
   int burst_left = 0;

   // Offers one request and holds it until taken. Valid stays high across a
   // burst and only drops during a gap.
   task automatic send_request(cmd_type c, bit use_fixed, rsp_type fixed);
      rsp_type r;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= c.mode;
      req_bus.request_size  <= c.request_size;
      req_bus.owner         <= c.owner;
      req_bus.block_address <= c.block_address;
      do @(posedge clock); while (!req_bus.ready);
      r = heap_predict(c);
      expected_rsp.push_back(use_fixed ? fixed : r);
      accepted++;
      if (c.mode == MODE_ALLOC && r.success) live_blocks.push_back(r.data_address);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == REG_HEAP_BASE) heap_base = value;
      else heap_size = value[12:0];
      heap_rebuild();
      live_blocks.delete();
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      cmd_type c;
      int pick, k;
      repeat (count) begin
         c = '0;
         c.owner = 8'($urandom_range(0, 255));
         c.block_address = 16'($urandom_range(0, 65535));
         pick = $urandom_range(0, 99);
         if (live_blocks.size() != 0 && (pick < 45 || live_blocks.size() > 24)) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            c.mode = MODE_FREE;
            c.block_address = live_blocks[k];
            live_blocks.delete(k);
         end else if (pick < 52) begin
            c.mode = MODE_FREE;
         end else begin
            c.mode = MODE_ALLOC;
            if ($urandom_range(0, 9) == 0) c.request_size = 13'($urandom_range(0, 8191));
            else c.request_size = 13'($urandom_range(0, heap_span / 6 + 1));
         end
         send_request(c, 1'b0, '0);
      end
   endtask

   typedef struct {
      cmd_type c;
      bit      fixed;
      rsp_type r;
   } dir_row;

   dir_row dir_table[$];

   function automatic dir_row mk(logic m, int sz, int own, int adr, bit fx, int ea, bit ok);
      dir_row d;
      d.c.mode = m;
      d.c.request_size = 13'(sz);
      d.c.owner = 8'(own);
      d.c.block_address = 16'(adr);
      d.fixed = fx;
      d.r.data_address = 16'(ea);
      d.r.success = ok;
      return d;
   endfunction

   // Receiver: a stall pattern drawn periodically from three kinds (always ready, random, sparse), plus one long hold.
   int stall_kind = 0;
   int stall_tick = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response with none expected: data_address %h", rsp_bus.data_address);
            errors++;
         end else begin
            if (rsp_bus.data_address !== expected_rsp[0].data_address) begin
               $error("data_address expected %h actual %h",
                      expected_rsp[0].data_address, rsp_bus.data_address);
               errors++;
            end
            if (rsp_bus.success !== expected_rsp[0].success) begin
               $error("success expected %b actual %b", expected_rsp[0].success, rsp_bus.success);
               errors++;
            end
            void'(expected_rsp.pop_front());
         end
      end
      stall_tick++;
      if (stall_tick % 64 == 0) stall_kind = $urandom_range(0, 2);
      if (!hold_done && accepted == 400) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (reset) rsp_bus.ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_kind == 0) rsp_bus.ready <= 1'b1;
      else if (stall_kind == 1) rsp_bus.ready <= ($urandom_range(0, 1) == 1);
      else rsp_bus.ready <= (stall_tick % 3 == 0);
   end

   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_ALLOC;
      req_bus.request_size = '0;
      req_bus.owner = '0;
      req_bus.block_address = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      heap_base = HEAP_BASE_RESET;
      heap_size = HEAP_SIZE_RESET;
      heap_rebuild();

      // After reset: one free block of 4090 bytes at 0x8000.
      dir_table.push_back(mk(MODE_ALLOC, 4096, 1, 0, 1, 0, 0));
      dir_table.push_back(mk(MODE_ALLOC, 8191, 2, 0, 1, 0, 0));
      dir_table.push_back(mk(MODE_FREE, 0, 0, 0, 1, 0, 0));
      dir_table.push_back(mk(MODE_FREE, 0, 0, 65535, 1, 0, 0));
      dir_table.push_back(mk(MODE_ALLOC, 0, 255, 0, 1, 32774, 1));
      dir_table.push_back(mk(MODE_FREE, 0, 0, 32774, 1, 32774, 1));
      dir_table.push_back(mk(MODE_ALLOC, 4090, 255, 0, 1, 32774, 1));
      dir_table.push_back(mk(MODE_FREE, 0, 0, 32774, 1, 32774, 1));
      dir_table.push_back(mk(MODE_ALLOC, 100, 170, 0, 0, 0, 0));
      dir_table.push_back(mk(MODE_ALLOC, 200, 85, 0, 0, 0, 0));
      dir_table.push_back(mk(MODE_ALLOC, 50, 0, 0, 0, 0, 0));
      dir_table.push_back(mk(MODE_FREE, 8191, 255, 32880, 0, 0, 0));
      dir_table.push_back(mk(MODE_FREE, 0, 0, 32880, 0, 0, 0));
      dir_table.push_back(mk(MODE_FREE, 0, 0, 32774, 0, 0, 0));
      dir_table.push_back(mk(MODE_FREE, 0, 0, 32881, 0, 0, 0));
      dir_table.push_back(mk(MODE_ALLOC, 300, 1, 0, 0, 0, 0));
      dir_table.push_back(mk(MODE_FREE, 0, 0, 33086, 0, 0, 0));
      dir_table.push_back(mk(MODE_ALLOC, 3700, 3, 0, 0, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (5) @(posedge clock);

      foreach (dir_table[i]) send_request(dir_table[i].c, dir_table[i].fixed, dir_table[i].r);
      random_phase(ITEMS_PHASE + 200);
      drain();

      write_reg(REG_HEAP_BASE, 16'h0000);
      write_reg(REG_HEAP_SIZE, 16'd4096);
      random_phase(ITEMS_PHASE);
      drain();

      // Small heap near the top of the address space; data addresses wrap.
      write_reg(REG_HEAP_BASE, 16'hFFF0);
      write_reg(REG_HEAP_SIZE, 16'd64);
      random_phase(ITEMS_PHASE / 2);
      drain();

      // Oversized region is clipped to the heap memory.
      write_reg(REG_HEAP_BASE, 16'h1234);
      write_reg(REG_HEAP_SIZE, 16'h1FFF);
      random_phase(ITEMS_PHASE);
      drain();

      write_reg(REG_HEAP_SIZE, 16'd16);
      random_phase(ITEMS_PHASE / 2);
      drain();

      // Region smaller than a header: everything fails.
      write_reg(REG_HEAP_SIZE, 16'd3);
      random_phase(40);
      drain();

      write_reg(REG_HEAP_BASE, 16'hFFFF);
      write_reg(REG_HEAP_SIZE, 16'd4096);
      random_phase(ITEMS_PHASE);
      drain();

      repeat (50) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_if.sv
sv/ffha_hdr_mem.sv
sv/ffha_engine.sv
sv/first_fit_heap_allocator_top.sv
test/first_fit_heap_allocator_top_tb.sv
